[hw/rtl/msb2_pkg.sv]
package msb2_pkg;

  // Default geometry of the framebuffer
  localparam int SCREEN_WIDTH_DEF   = 120;
  localparam int SCREEN_HEIGHT_DEF  = 60;
  localparam int BYTES_PER_LINE_DEF = 30;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_SPRITE = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DEST_X        = 3'd2;
  localparam logic [2:0] REG_DEST_Y        = 3'd3;
  localparam logic [2:0] REG_MASK_ENABLE   = 3'd4;

  // Read-modify-write request to one framebuffer bank: new = (old & and_bits) | or_bits
  typedef struct packed {
    logic       wr;
    logic [7:0] and_bits;
    logic [7:0] or_bits;
  } msb2_rmw_t;

endpackage

[hw/rtl/msb2_bank.sv]
module msb2_bank #(
  parameter int DEPTH = 900,
  parameter int IDX_W = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [IDX_W-1:0]    rd_idx,
  input  msb2_pkg::msb2_rmw_t rmw,
  input  logic                clear,
  input  logic [IDX_W-1:0]    clear_idx,
  output logic [7:0]          old_data
);

  logic [7:0]       mem [DEPTH];
  logic [7:0]       q;

  // Second stage of the read-modify-write
  logic             s1_wr;
  logic [IDX_W-1:0] s1_idx;
  logic [7:0]       s1_and;
  logic [7:0]       s1_or;

  // Copy of the last write, for a read that raced it
  logic             hold_en;
  logic [IDX_W-1:0] hold_idx;
  logic [7:0]       hold_data;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [7:0]       wr_data;

  // Bypass: the read issued at the edge of the previous write saw stale data
  assign old_data = (hold_en && (hold_idx == s1_idx)) ? hold_data : q;

  // Write port: clearing sweep or the modified byte
  always_comb begin
    wr_en   = clear | s1_wr;
    wr_idx  = clear ? clear_idx : s1_idx;
    wr_data = clear ? 8'h00 : ((old_data & s1_and) | s1_or);
  end

  // Memory array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    q <= mem[rd_idx];
  end

  // Request capture and write history
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_wr   <= 1'b0;
      hold_en <= 1'b0;
    end else begin
      s1_wr   <= go & rmw.wr;
      hold_en <= wr_en;
    end
    s1_idx    <= rd_idx;
    s1_and    <= rmw.and_bits;
    s1_or     <= rmw.or_bits;
    hold_idx  <= wr_idx;
    hold_data <= wr_data;
  end

endmodule

[hw/rtl/masked_sprite_blitter_2bpp.sv]
// Masked 2-bit-per-pixel sprite blitter. The block owns a framebuffer of
// SCREEN_HEIGHT lines of BYTES_PER_LINE bytes, four pixels to a byte with the
// leftmost pixel in bits 7:6. Op 0 draws one sprite byte (four pixels) at the
// current sprite row and byte column, clipped to the screen, either masked
// (AND mask, then OR sprite) or as a plain overwrite; op 1 writes and op 2 reads
// one framebuffer byte. Every transaction yields exactly one result; blit_done
// flags the sprite's last byte. The framebuffer is split into two banks by
// address parity, so the up to two adjacent bytes a sprite byte touches each
// get one read-modify-write in their own bank; a one-entry bypass per bank
// covers a transaction that reads a byte the previous one is writing. The block
// sustains one transaction per clock while the result queue has room. A result
// passes through the second-stage registers into a three-entry result queue;
// when the output stalls, input keeps flowing until queue and second stage hold
// three results, then in_stall rises. After reset the block clears the
// framebuffer, one entry of each bank per cycle, with in_stall held high;
// configuration writes are taken during that time.
module masked_sprite_blitter_2bpp #(
  parameter int SCREEN_WIDTH   = msb2_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT  = msb2_pkg::SCREEN_HEIGHT_DEF,
  parameter int BYTES_PER_LINE = msb2_pkg::BYTES_PER_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  sprite_byte,
  input  logic [7:0]  mask_byte,
  input  logic [10:0] fb_address,
  input  logic [7:0]  fb_data,
  // Output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        blit_done
);

  localparam int FB_BYTES   = BYTES_PER_LINE * SCREEN_HEIGHT;
  localparam int ADDR_W     = $clog2(FB_BYTES) + 1;
  localparam int BANK_DEPTH = (FB_BYTES + 1) / 2;
  localparam int IDX_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int FIFO_DEPTH = 3;

  // Configuration registers
  logic [7:0]        sprite_width;
  logic [7:0]        sprite_height;
  logic signed [7:0] dest_x;
  logic signed [7:0] dest_y;
  logic              mask_enable;

  // Sprite walk counters
  logic [7:0] sprite_row;
  logic [5:0] sprite_byte_column;
  logic [7:0] sprite_row_next;
  logic [5:0] sprite_byte_column_next;
  logic       last_byte;

  // Clearing sweep
  logic             clearing;
  logic [IDX_W-1:0] clear_idx;

  // Bank requests
  msb2_pkg::msb2_rmw_t bank_rmw [2];
  logic [IDX_W-1:0]    bank_idx [2];
  logic [7:0]          bank_old [2];

  // Second stage
  logic s1_valid;
  logic s1_read;
  logic s1_bank;
  logic s1_done;

  // Result queue
  logic [7:0] fifo_data [FIFO_DEPTH];
  logic       fifo_done [FIFO_DEPTH];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  logic accept;
  logic read_hit;
  logic fb_in_range;

  assign accept      = in_valid & ~in_stall;
  assign fb_in_range = 32'(fb_address) < FB_BYTES;
  assign read_hit    = (op == msb2_pkg::OP_READ) && fb_in_range;
  assign in_stall    = clearing | ((3'(count) + 3'(s1_valid)) >= 3'(FIFO_DEPTH));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width  <= 8'd0;
      sprite_height <= 8'd0;
      dest_x        <= 8'sd0;
      dest_y        <= 8'sd0;
      mask_enable   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        msb2_pkg::REG_SPRITE_WIDTH:  sprite_width  <= cfg_data;
        msb2_pkg::REG_SPRITE_HEIGHT: sprite_height <= cfg_data;
        msb2_pkg::REG_DEST_X:        dest_x        <= cfg_data;
        msb2_pkg::REG_DEST_Y:        dest_y        <= cfg_data;
        msb2_pkg::REG_MASK_ENABLE:   mask_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Row and column advance for a sprite byte
  always_comb begin
    logic [6:0] line_bytes;
    logic       row_end;
    line_bytes = 7'(({1'b0, sprite_width} + 9'd3) >> 2);
    row_end    = ({1'b0, sprite_byte_column} + 7'd1) >= line_bytes;
    last_byte  = row_end && (({1'b0, sprite_row} + 9'd1) >= {1'b0, sprite_height});
    sprite_byte_column_next = row_end ? 6'd0 : sprite_byte_column + 6'd1;
    if (!row_end) begin
      sprite_row_next = sprite_row;
    end else if (last_byte) begin
      sprite_row_next = 8'd0;
    end else begin
      sprite_row_next = sprite_row + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_row         <= 8'd0;
      sprite_byte_column <= 6'd0;
    end else if (accept && (op == msb2_pkg::OP_SPRITE)) begin
      sprite_row         <= sprite_row_next;
      sprite_byte_column <= sprite_byte_column_next;
    end
  end

  // Per-bank request: address, AND bits and OR bits
  always_comb begin
    logic signed [9:0] x0;
    logic signed [9:0] xk;
    logic signed [9:0] y;
    logic              y_ok;
    logic [ADDR_W-1:0] line_base;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        sx;
    logic [7:0]        col;
    logic [2:0]        sh;
    logic [7:0]        pm;
    logic [1:0]        spix;
    logic [1:0]        mpix;
    logic              pv;
    x0        = {{2{dest_x[7]}}, dest_x} + {2'b00, sprite_byte_column, 2'b00};
    y         = {{2{dest_y[7]}}, dest_y} + {2'b00, sprite_row};
    y_ok      = !y[9] && ($unsigned(y) < 10'(SCREEN_HEIGHT));
    line_base = ADDR_W'(32'(y[7:0]) * BYTES_PER_LINE);
    for (int b = 0; b < 2; b++) begin
      bank_rmw[b] = '{wr: 1'b0, and_bits: 8'hFF, or_bits: 8'h00};
      bank_idx[b] = '0;
    end
    case (op)
      msb2_pkg::OP_SPRITE: begin
        for (int k = 0; k < 4; k++) begin
          xk   = x0 + 10'(k);
          sx   = {sprite_byte_column, 2'b00} + 8'(k);
          col  = xk[9:2];
          addr = line_base + ADDR_W'(col);
          pv   = y_ok && (sx < sprite_width) && !xk[9]
                 && ($unsigned(xk) < 10'(SCREEN_WIDTH))
                 && (32'(col) < BYTES_PER_LINE) && (32'(addr) < FB_BYTES);
          sh   = {~xk[1:0], 1'b0};
          pm   = 8'b0000_0011 << sh;
          spix = sprite_byte[(7 - 2 * k) -: 2];
          mpix = mask_byte[(7 - 2 * k) -: 2];
          for (int b = 0; b < 2; b++) begin
            if (pv && (addr[0] == b[0])) begin
              bank_rmw[b].wr       = 1'b1;
              bank_rmw[b].and_bits = bank_rmw[b].and_bits
                                     & (mask_enable ? ((8'(mpix) << sh) | ~pm) : ~pm);
              bank_rmw[b].or_bits  = bank_rmw[b].or_bits | (8'(spix) << sh);
              bank_idx[b]          = bank_idx[b] | IDX_W'(addr >> 1);
            end
          end
        end
      end
      msb2_pkg::OP_WRITE: begin
        for (int b = 0; b < 2; b++) begin
          bank_idx[b] = IDX_W'(fb_address >> 1);
          if (fb_in_range && (fb_address[0] == b[0])) begin
            bank_rmw[b] = '{wr: 1'b1, and_bits: 8'h00, or_bits: fb_data};
          end
        end
      end
      msb2_pkg::OP_READ: begin
        for (int b = 0; b < 2; b++) begin
          bank_idx[b] = IDX_W'(fb_address >> 1);
        end
      end
      default: ;
    endcase
  end

  // Framebuffer banks, even and odd byte addresses
  for (genvar g = 0; g < 2; g++) begin : g_bank
    msb2_bank #(
      .DEPTH (BANK_DEPTH),
      .IDX_W (IDX_W)
    ) u_bank (
      .clk       (clk),
      .rst       (rst),
      .go        (accept),
      .rd_idx    (bank_idx[g]),
      .rmw       (bank_rmw[g]),
      .clear     (clearing),
      .clear_idx (clear_idx),
      .old_data  (bank_old[g])
    );
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_idx <= '0;
    end else if (clearing) begin
      if (clear_idx == IDX_W'(BANK_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clear_idx <= clear_idx + IDX_W'(1);
    end
  end

  // Second stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_read <= read_hit;
    s1_bank <= fb_address[0];
    s1_done <= (op == msb2_pkg::OP_SPRITE) && last_byte;
  end

  // Result queue
  assign push      = s1_valid;
  assign pop       = out_valid & ~out_stall;
  assign out_valid = count != 2'd0;
  assign read_data = fifo_data[rptr];
  assign blit_done = fifo_done[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 2'd0;
      rptr  <= 2'd0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= (wptr == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wptr + 2'd1;
      end
      if (pop) begin
        rptr <= (rptr == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rptr + 2'd1;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      fifo_data[wptr] <= s1_read ? bank_old[s1_bank] : 8'h00;
      fifo_done[wptr] <= s1_done;
    end
  end

endmodule

[verif/msb2_frame_checker.sv]
`timescale 1ns / 1ps
module msb2_frame_checker
  import msb2_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  sprite_byte,
  input  logic [7:0]  mask_byte,
  input  logic [10:0] fb_address,
  input  logic [7:0]  fb_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  read_data,
  input  logic        blit_done,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          sprites_done
);

  localparam int FB_BYTES     = BYTES_PER_LINE_DEF * SCREEN_HEIGHT_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [7:0] read_data;
    logic       blit_done;
  } blit_result_t;

  // Shadow framebuffer, sprite walk counters and register copies
  logic [7:0]   frame_model [FB_BYTES];
  logic [7:0]   row_count;
  logic [5:0]   col_count;
  logic [7:0]   width_reg;
  logic [7:0]   height_reg;
  logic [7:0]   dest_x_reg;
  logic [7:0]   dest_y_reg;
  logic         mask_reg;
  blit_result_t expected_q [$];

  // Merge one 2-bit pixel into the shadow frame; off-screen pixels are dropped
  function automatic void plot_pixel(int px, int py, logic [1:0] spix, logic [1:0] mpix);
    int         addr;
    int         shift;
    logic [7:0] lane;
    logic [7:0] fb_byte;
    if (px < 0 || px >= SCREEN_WIDTH_DEF || py < 0 || py >= SCREEN_HEIGHT_DEF) return;
    if ((px >> 2) >= BYTES_PER_LINE_DEF) return;
    addr = py * BYTES_PER_LINE_DEF + (px >> 2);
    if (addr >= FB_BYTES) return;
    shift   = 6 - 2 * (px & 3);
    lane    = 8'h03 << shift;
    fb_byte = frame_model[addr];
    if (mask_reg) begin
      fb_byte = (fb_byte & ((8'(mpix) << shift) | ~lane)) | (8'(spix) << shift);
    end else begin
      fb_byte = (fb_byte & ~lane) | (8'(spix) << shift);
    end
    frame_model[addr] = fb_byte;
  endfunction

  // Apply one input transaction to the shadow state and return its result
  function automatic blit_result_t apply_transaction(logic [1:0] opc, logic [7:0] sb,
                                                     logic [7:0] mb, logic [10:0] addr,
                                                     logic [7:0] data);
    blit_result_t res;
    int           line_bytes;
    int           sx;
    int           py;
    int           shift;
    res = '0;
    case (opc)
      OP_SPRITE: begin
        line_bytes = (int'(width_reg) + 3) >> 2;
        py = int'($signed(dest_y_reg)) + int'(row_count);
        for (int k = 0; k < 4; k++) begin
          sx    = int'(col_count) * 4 + k;
          shift = 6 - 2 * k;
          // pixels past the sprite width are padding
          if (sx < int'(width_reg))
            plot_pixel(int'($signed(dest_x_reg)) + sx, py, sb[shift +: 2], mb[shift +: 2]);
        end
        // row ends once the column reaches the (possibly new) row length
        if (int'(col_count) + 1 >= line_bytes) begin
          col_count = '0;
          if (int'(row_count) + 1 >= int'(height_reg)) begin
            row_count     = '0;
            res.blit_done = 1'b1;
          end else begin
            row_count = row_count + 8'd1;
          end
        end else begin
          col_count = col_count + 6'd1;
        end
      end
      OP_WRITE: begin
        if (int'(addr) < FB_BYTES) frame_model[addr] = data;
      end
      OP_READ: begin
        if (int'(addr) < FB_BYTES) res.read_data = frame_model[addr];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Track config writes, check results, predict accepted transactions
  always @(posedge clk) begin
    blit_result_t want;
    if (rst) begin
      foreach (frame_model[i]) frame_model[i] = '0;
      row_count  = '0;
      col_count  = '0;
      width_reg  = '0;
      height_reg = '0;
      dest_x_reg = '0;
      dest_y_reg = '0;
      mask_reg   = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SPRITE_WIDTH:  width_reg  = cfg_data;
          REG_SPRITE_HEIGHT: height_reg = cfg_data;
          REG_DEST_X:        dest_x_reg = cfg_data;
          REG_DEST_Y:        dest_y_reg = cfg_data;
          REG_MASK_ENABLE:   mask_reg   = cfg_data[0];
          default: ;
        endcase
      end

      // result side: compare against the oldest expectation
      if (out_valid && !out_stall) begin
        results_seen++;
        if (blit_done) sprites_done++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("checker: result %0d with nothing expected (read_data %02h blit_done %0d)",
                     results_seen, read_data, blit_done);
        end else begin
          want = expected_q.pop_front();
          if (want.read_data !== read_data || want.blit_done !== blit_done) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display("checker: result %0d read_data exp %02h got %02h, blit_done exp %0d got %0d",
                       results_seen, want.read_data, read_data, want.blit_done, blit_done);
          end
        end
      end

      // input side: one expectation per accepted transaction
      if (in_valid && !in_stall)
        expected_q.push_back(apply_transaction(op, sprite_byte, mask_byte, fb_address, fb_data));
    end
    pending = expected_q.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import msb2_pkg::*;

  localparam int FB_BYTES         = BYTES_PER_LINE_DEF * SCREEN_HEIGHT_DEF;
  localparam int RANDOM_ITEMS     = 1250;
  localparam int CYCLE_LIMIT      = 500000;
  localparam int IDLE_MAX         = 13;
  localparam int MAX_SPRITE_BYTES = 80;
  localparam int HOLD_CYCLES      = 400;
  localparam int HOLD_AT_FIRST    = 150;
  localparam int HOLD_AT_SECOND   = 900;
  localparam int SETTLE_CYCLES    = 8;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_SPARE = 3'd5;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_write   = 1'b0;
  logic [2:0]  cfg_index   = REG_SPRITE_WIDTH;
  logic [7:0]  cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  op          = OP_SPRITE;
  logic [7:0]  sprite_byte = '0;
  logic [7:0]  mask_byte   = '0;
  logic [10:0] fb_address  = '0;
  logic [7:0]  fb_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [7:0]  read_data;
  logic        blit_done;

  int fail_count;
  int pending;
  int results_seen;
  int sprites_done;
  int items_sent;
  int settings_used;
  bit sender_quiet;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  masked_sprite_blitter_2bpp DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .op, .sprite_byte, .mask_byte, .fb_address, .fb_data,
    .out_valid, .out_stall, .read_data, .blit_done
  );

  msb2_frame_checker frame_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .op, .sprite_byte, .mask_byte, .fb_address, .fb_data,
    .out_valid, .out_stall, .read_data, .blit_done,
    .fail_count, .pending, .results_seen, .sprites_done
  );

  // Offer one transaction, after a random gap unless the sender is quiet, and hold it until taken
  task automatic send_txn(input logic [1:0] opc, input logic [7:0] sb, input logic [7:0] mb,
                          input logic [10:0] addr, input logic [7:0] data);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= opc;
    sprite_byte <= sb;
    mask_byte   <= mb;
    fb_address  <= addr;
    fb_data     <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (opc != OP_UNUSED) items_sent++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // Full register setup; upper mask bits and spare indexes must be ignored
  task automatic program_blit(input logic [7:0] w, input logic [7:0] h, input logic [7:0] x,
                              input logic [7:0] y, input logic m);
    write_reg(REG_SPRITE_WIDTH, w);
    write_reg(REG_SPRITE_HEIGHT, h);
    write_reg(REG_DEST_X, x);
    write_reg(REG_DEST_Y, y);
    write_reg(REG_MASK_ENABLE, {7'($urandom), m});
    if ($urandom_range(0, 1) == 1)
      write_reg(REG_SPARE + 3'($urandom_range(0, 2)), 8'($urandom));
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Stray framebuffer access or unused op between sprite bytes
  task automatic send_noise();
    int          pick;
    logic [10:0] addr;
    pick = $urandom_range(0, 9);
    addr = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(FB_BYTES, 2047))
                                       : 11'($urandom_range(0, FB_BYTES - 1));
    if (pick < 4)
      send_txn(OP_WRITE, 8'($urandom), 8'($urandom), addr, 8'($urandom));
    else if (pick < 9)
      send_txn(OP_READ, 8'($urandom), 8'($urandom), addr, 8'($urandom));
    else
      send_txn(OP_UNUSED, 8'($urandom), 8'($urandom), addr, 8'($urandom));
  endtask

  // One random sprite: new registers, its data bytes, then a readback
  task automatic run_blit_phase();
    int         w;
    int         h;
    int         dx;
    int         dy;
    int         row_bytes;
    int         n_bytes;
    int         roll;
    int         px;
    int         py;
    logic       m;
    logic [7:0] mb;
    w  = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 255 : 0)
                                     : $urandom_range(1, 16);
    h  = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 255 : 0)
                                     : $urandom_range(1, 4);
    dx = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 127 : -128)
                                     : int'($urandom_range(0, 135)) - 12;
    dy = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 127 : -128)
                                     : int'($urandom_range(0, 67)) - 6;
    m  = 1'($urandom_range(0, 1));
    sender_quiet = ($urandom_range(0, 4) == 0);

    wait_drained();
    program_blit(8'(w), 8'(h), 8'(dx), 8'(dy), m);

    row_bytes = (w + 3) >> 2;
    n_bytes   = ((row_bytes == 0) ? 1 : row_bytes) * ((h == 0) ? 1 : h);
    // sometimes cut short (next setup lands mid-blit) or run into the next sprite
    roll = $urandom_range(0, 5);
    if (roll == 0) n_bytes = $urandom_range(1, n_bytes);
    else if (roll == 1) n_bytes += $urandom_range(1, 3);
    if (n_bytes > MAX_SPRITE_BYTES) n_bytes = $urandom_range(1, MAX_SPRITE_BYTES);

    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      case ($urandom_range(0, 3))
        0:       mb = 8'h00;
        1:       mb = 8'hFF;
        default: mb = 8'($urandom);
      endcase
      send_txn(OP_SPRITE, 8'($urandom), mb, 11'($urandom), 8'($urandom));
    end

    // read back bytes under the sprite where they are on screen
    repeat ($urandom_range(1, 4)) begin
      px = dx + int'($urandom_range(0, w));
      py = dy + int'($urandom_range(0, (h == 0) ? 0 : h - 1));
      if (px >= 0 && px < SCREEN_WIDTH_DEF && py >= 0 && py < SCREEN_HEIGHT_DEF)
        send_txn(OP_READ, 8'($urandom), 8'($urandom),
                 11'(py * BYTES_PER_LINE_DEF + (px >> 2)), 8'($urandom));
      else
        send_txn(OP_READ, 8'($urandom), 8'($urandom),
                 11'($urandom_range(0, FB_BYTES - 1)), 8'($urandom));
    end
  endtask

  // Stimulus and verdict
  initial begin
    int random_start;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // registers go in while the framebuffer clear is still running
    program_blit(8'd8, 8'd1, 8'd0, 8'd0, 1'b0);

    // framebuffer edges, out-of-range addresses, unused op
    send_txn(OP_READ, 8'h00, 8'h00, 11'd0, 8'h00);
    send_txn(OP_READ, 8'hFF, 8'hFF, 11'(FB_BYTES - 1), 8'hFF);
    send_txn(OP_WRITE, 8'h00, 8'h00, 11'd0, 8'hFF);
    send_txn(OP_WRITE, 8'h00, 8'h00, 11'(FB_BYTES - 1), 8'hA5);
    send_txn(OP_WRITE, 8'h00, 8'h00, 11'(FB_BYTES), 8'h3C);
    send_txn(OP_WRITE, 8'h00, 8'h00, 11'h7FF, 8'hFF);
    send_txn(OP_READ, 8'h00, 8'h00, 11'(FB_BYTES - 1), 8'h00);
    send_txn(OP_READ, 8'h00, 8'h00, 11'h7FF, 8'h00);
    send_txn(OP_UNUSED, 8'hFF, 8'hFF, 11'h7FF, 8'hFF);

    // plain overwrite, one row of two bytes
    send_txn(OP_SPRITE, 8'h1B, 8'h00, 11'd0, 8'h00);
    send_txn(OP_SPRITE, 8'hE4, 8'hFF, 11'd0, 8'h00);
    send_txn(OP_READ, 8'h00, 8'h00, 11'd0, 8'h00);

    // masked, partial last byte, clipped at left and top
    wait_drained();
    program_blit(8'd7, 8'd2, 8'hFD, 8'hFF, 1'b1);
    send_txn(OP_SPRITE, 8'hFF, 8'h00, 11'd0, 8'h00);
    send_txn(OP_SPRITE, 8'h55, 8'hAA, 11'd0, 8'h00);
    send_txn(OP_SPRITE, 8'h00, 8'hFF, 11'd0, 8'h00);
    send_txn(OP_SPRITE, 8'hAA, 8'h55, 11'd0, 8'h00);
    send_txn(OP_READ, 8'h00, 8'h00, 11'd0, 8'h00);

    // zero width and zero height: every byte finishes the sprite
    wait_drained();
    program_blit(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_txn(OP_SPRITE, 8'hFF, 8'hFF, 11'd0, 8'h00);
    send_txn(OP_SPRITE, 8'hFF, 8'hFF, 11'd0, 8'h00);

    // clipped at right and bottom; second row falls off the screen
    wait_drained();
    program_blit(8'd12, 8'd2, 8'd113, 8'd59, 1'b1);
    repeat (6) send_txn(OP_SPRITE, 8'($urandom), 8'($urandom), 11'd0, 8'h00);
    send_txn(OP_READ, 8'h00, 8'h00, 11'(FB_BYTES - 1), 8'h00);

    // registers rewritten in the middle of a row
    wait_drained();
    program_blit(8'd8, 8'd3, 8'd127, 8'd127, 1'b0);
    send_txn(OP_SPRITE, 8'hC3, 8'h3C, 11'd0, 8'h00);
    wait_drained();
    program_blit(8'd4, 8'd3, 8'h80, 8'h80, 1'b1);
    send_txn(OP_SPRITE, 8'h3C, 8'hC3, 11'd0, 8'h00);

    // random sprites with noise mixed in
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) run_blit_phase();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d transactions checked under %0d register setups, %0d sprites finished",
             results_seen, settings_used, sprites_done);
    $display("tb: covered clipping on all edges, masked and plain blits, mid-blit updates");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Result side: random stall per transaction, quiet stretches, two long hold-offs
  initial begin
    int  stall_cycles;
    int  taken;
    bit  quiet;
    taken = 0;
    quiet = 1'b0;
    @(posedge clk);
    forever begin
      if (taken % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT_FIRST || taken == HOLD_AT_SECOND)
        stall_cycles = HOLD_CYCLES;
      else
        stall_cycles = quiet ? 0 : $urandom_range(0, IDLE_MAX);
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: no finish within %0d cycles", CYCLE_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/msb2_pkg.sv
hw/rtl/msb2_bank.sv
hw/rtl/masked_sprite_blitter_2bpp.sv
verif/msb2_frame_checker.sv
verif/tb.sv
